// File: rtl/core/mcbm_pkg.sv
// Shared constants, payload types and state codes of the bipartite matching block.
// No dependencies; every other file imports this package.
package mcbm_pkg;

  localparam int MAX_PAIRS   = 64;
  localparam int MAX_EDGES   = 4096;
  localparam int WEIGHT_BITS = 12;

  localparam int NODE_W  = $clog2(MAX_PAIRS);
  localparam int PAIR_W  = 7;
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int CNT_W   = EDGE_AW + 1;
  localparam int COST_W  = 18;
  localparam int DIST_W  = 21;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Stored edge plus its residual direction (flow set means matched, arc reversed).
  typedef struct packed {
    logic                   flow;
    logic [WEIGHT_BITS-1:0] weight;
    logic [NODE_W-1:0]      to_node;
    logic [NODE_W-1:0]      from_node;
  } edge_word_t;

  typedef struct packed {
    logic [EDGE_AW-1:0]       pred;
    logic signed [DIST_W-1:0] dval;
  } dist_word_t;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_SEARCH    = 12'b000000000010,
    S_E_ADDR    = 12'b000000000100,
    S_E_DATA    = 12'b000000001000,
    S_RELAX     = 12'b000000010000,
    S_SINK_ADDR = 12'b000000100000,
    S_SINK_CHK  = 12'b000001000000,
    S_AUG_R     = 12'b000010000000,
    S_AUG_E     = 12'b000100000000,
    S_AUG_F     = 12'b001000000000,
    S_AUG_L     = 12'b010000000000,
    S_AUG_B     = 12'b100000000000
  } state_t;

endpackage

// File: rtl/core/mcbm_edge_if.sv
// Edge input channel: valid/ready handshake with one edge as payload.
// Depends on mcbm_pkg.
interface mcbm_edge_if import mcbm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [NODE_W-1:0]      from_node;
  logic [NODE_W-1:0]      to_node;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_edge;

  modport source (output valid, from_node, to_node, weight, last_edge, input ready);
  modport sink   (input valid, from_node, to_node, weight, last_edge, output ready);
endinterface

// File: rtl/core/mcbm_result_if.sv
// Result output channel: valid/ready handshake with status and total cost.
// Depends on mcbm_pkg.
interface mcbm_result_if import mcbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [COST_W-1:0] total_cost;

  modport source (output valid, status, total_cost, input ready);
  modport sink   (input valid, status, total_cost, output ready);
endinterface

// File: rtl/core/min_cost_bipartite_matching_top.sv
// Minimum-cost perfect matching engine: edge memory, two distance memories, control.
// Depends on mcbm_pkg, mcbm_edge_if and mcbm_result_if.
//
// Edges are taken one per cycle into a 4096-entry edge memory. The transfer flagged
// last_edge starts the search: successive shortest augmenting paths, each found by
// Bellman-Ford passes over the edge memory. Each search opens with a setup state, then
// a pass steps through every stored edge (edge read, distance read, relax/write) and
// passes repeat until no distance changes; then the right-side distances are scanned
// node by node and the path is walked back over its forward and backward arcs. One
// search runs per matched pair. No new edge is taken while a search runs or a result
// waits. An overflowed store reports at once.
module min_cost_bipartite_matching_top import mcbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PAIR_W-1:0] cfg_data,
  mcbm_edge_if.sink         edge_in,
  mcbm_result_if.source     result_out
);

  state_t state;

  logic [PAIR_W-1:0]  pair_count;
  logic [PAIR_W-1:0]  n_eff;
  logic [CNT_W-1:0]   edge_count;
  logic               overflow;
  logic [EDGE_AW-1:0] idx;
  logic [EDGE_AW-1:0] cur_idx;
  logic               changed;
  logic [MAX_PAIRS-1:0] src_used, sink_used, wr_l, wr_r;
  logic [PAIR_W-1:0]  found;
  logic [PAIR_W-1:0]  k;
  logic [NODE_W-1:0]  k_q;
  logic               best_ok;
  logic [NODE_W-1:0]  best_v;
  logic signed [DIST_W-1:0] best_d;
  logic [NODE_W-1:0]  aug_v;
  logic signed [DIST_W-1:0] total;
  edge_word_t         cur;

  logic               out_valid;
  logic [1:0]         out_status;
  logic [COST_W-1:0]  out_cost;

  // memories
  edge_word_t edge_mem [MAX_EDGES];
  dist_word_t dist_l_mem [MAX_PAIRS];
  dist_word_t dist_r_mem [MAX_PAIRS];
  edge_word_t em_q;
  dist_word_t dl_q, dr_q;

  logic               em_we;
  logic [EDGE_AW-1:0] em_waddr, em_raddr;
  edge_word_t         em_wdata;
  logic [NODE_W-1:0]  dr_raddr;

  logic in_xfer, out_xfer, store_full;
  logic valid_e, l_reach, upd_l, upd_r;
  logic signed [DIST_W-1:0] l_d, w_s, cand_f, cand_b, aug_w;

  always_comb begin
    if (pair_count == '0) n_eff = PAIR_W'(1);
    else if (pair_count > PAIR_W'(MAX_PAIRS)) n_eff = PAIR_W'(MAX_PAIRS);
    else n_eff = pair_count;
  end

  assign edge_in.ready = (state == S_IDLE) && !out_valid;
  assign in_xfer  = edge_in.valid && edge_in.ready;
  assign out_xfer = out_valid && result_out.ready;
  assign store_full = (edge_count == CNT_W'(MAX_EDGES));

  assign result_out.valid      = out_valid;
  assign result_out.status     = out_status;
  assign result_out.total_cost = out_cost;

  // relaxation of the current edge in its residual direction
  assign valid_e = ({1'b0, cur.from_node} < n_eff) && ({1'b0, cur.to_node} < n_eff);
  assign l_reach = wr_l[cur.from_node] | ~src_used[cur.from_node];
  assign l_d     = wr_l[cur.from_node] ? dl_q.dval : '0;
  assign w_s     = $signed({{(DIST_W-WEIGHT_BITS){1'b0}}, cur.weight});
  assign cand_f  = l_d + w_s;
  assign cand_b  = dr_q.dval - w_s;
  assign upd_r = (state == S_RELAX) && valid_e && !cur.flow && l_reach &&
                 (!wr_r[cur.to_node] || cand_f < dr_q.dval);
  assign upd_l = (state == S_RELAX) && valid_e && cur.flow && wr_r[cur.to_node] &&
                 (!l_reach || cand_b < l_d);
  assign aug_w = $signed({{(DIST_W-WEIGHT_BITS){1'b0}}, em_q.weight});

  always_comb begin
    em_we    = 1'b0;
    em_waddr = cur_idx;
    em_wdata = em_q;
    if (state == S_IDLE) begin
      em_we    = in_xfer && !store_full;
      em_waddr = edge_count[EDGE_AW-1:0];
      em_wdata = '{flow: 1'b0, weight: edge_in.weight, to_node: edge_in.to_node,
                   from_node: edge_in.from_node};
    end else if (state == S_AUG_F) begin
      em_we         = 1'b1;
      em_wdata.flow = 1'b1;
    end else if (state == S_AUG_B) begin
      em_we         = 1'b1;
      em_wdata.flow = 1'b0;
    end
  end

  always_comb begin
    if (state == S_AUG_E) em_raddr = dr_q.pred;
    else if (state == S_AUG_L) em_raddr = dl_q.pred;
    else em_raddr = idx;
  end

  always_comb begin
    if (state == S_SINK_ADDR) dr_raddr = k[NODE_W-1:0];
    else if (state == S_AUG_R) dr_raddr = aug_v;
    else dr_raddr = em_q.to_node;
  end

  always_ff @(posedge clk) begin
    if (em_we) edge_mem[em_waddr] <= em_wdata;
    em_q <= edge_mem[em_raddr];
  end

  always_ff @(posedge clk) begin
    if (upd_l) dist_l_mem[cur.from_node] <= '{pred: idx, dval: cand_b};
    dl_q <= dist_l_mem[em_q.from_node];
  end

  always_ff @(posedge clk) begin
    if (upd_r) dist_r_mem[cur.to_node] <= '{pred: idx, dval: cand_f};
    dr_q <= dist_r_mem[dr_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pair_count <= PAIR_W'(1);
      edge_count <= '0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
      src_used   <= '0;
      sink_used  <= '0;
      wr_l       <= '0;
      wr_r       <= '0;
      found      <= '0;
      idx        <= '0;
      changed    <= 1'b0;
      k          <= '0;
      best_ok    <= 1'b0;
    end else begin
      if (cfg_we) pair_count <= cfg_data;
      if (out_xfer) out_valid <= 1'b0;
      if (upd_l) wr_l[cur.from_node] <= 1'b1;
      if (upd_r) wr_r[cur.to_node] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (edge_in.last_edge && (overflow || store_full)) begin
              out_valid  <= 1'b1;
              out_status <= ST_OVERFLOW;
              out_cost   <= '0;
              edge_count <= '0;
              overflow   <= 1'b0;
            end else begin
              if (store_full) overflow <= 1'b1;
              else edge_count <= edge_count + CNT_W'(1);
              if (edge_in.last_edge) begin
                src_used  <= '0;
                sink_used <= '0;
                found     <= '0;
                total     <= '0;
                state     <= S_SEARCH;
              end
            end
          end
        end
        S_SEARCH: begin
          wr_l    <= '0;
          wr_r    <= '0;
          idx     <= '0;
          changed <= 1'b0;
          k       <= '0;
          best_ok <= 1'b0;
          state   <= (edge_count == '0) ? S_SINK_ADDR : S_E_ADDR;
        end
        S_E_ADDR: state <= S_E_DATA;
        S_E_DATA: begin
          cur   <= em_q;
          state <= S_RELAX;
        end
        S_RELAX: begin
          if ({1'b0, idx} + CNT_W'(1) == edge_count) begin
            idx <= '0;
            if (changed || upd_l || upd_r) begin
              changed <= 1'b0;
              state   <= S_E_ADDR;
            end else begin
              state <= S_SINK_ADDR;
            end
          end else begin
            idx     <= idx + EDGE_AW'(1);
            changed <= changed | upd_l | upd_r;
            state   <= S_E_ADDR;
          end
        end
        S_SINK_ADDR: begin
          k_q   <= k[NODE_W-1:0];
          state <= S_SINK_CHK;
        end
        S_SINK_CHK: begin
          if (wr_r[k_q] && !sink_used[k_q] && (!best_ok || dr_q.dval < best_d)) begin
            best_ok <= 1'b1;
            best_v  <= k_q;
            best_d  <= dr_q.dval;
          end
          if (k + PAIR_W'(1) == n_eff) begin
            if (best_ok || (wr_r[k_q] && !sink_used[k_q])) begin
              aug_v <= (best_ok && !(wr_r[k_q] && !sink_used[k_q] && dr_q.dval < best_d))
                       ? best_v : k_q;
              state <= S_AUG_R;
            end else begin
              out_valid  <= 1'b1;
              out_status <= ST_NO_MATCH;
              out_cost   <= '0;
              edge_count <= '0;
              overflow   <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            k     <= k + PAIR_W'(1);
            state <= S_SINK_ADDR;
          end
        end
        S_AUG_R: begin
          sink_used[aug_v] <= 1'b1;
          state <= S_AUG_E;
        end
        S_AUG_E: begin
          cur_idx <= dr_q.pred;
          state   <= S_AUG_F;
        end
        S_AUG_F: begin
          total <= total + aug_w;
          if (wr_l[em_q.from_node]) begin
            state <= S_AUG_L;
          end else begin
            // path started at the source arc of this left node
            src_used[em_q.from_node] <= 1'b1;
            found <= found + PAIR_W'(1);
            if (found + PAIR_W'(1) == n_eff) begin
              out_valid  <= 1'b1;
              out_status <= ST_OK;
              out_cost   <= total[COST_W-1:0] + COST_W'(em_q.weight);
              edge_count <= '0;
              overflow   <= 1'b0;
              state      <= S_IDLE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_AUG_L: begin
          cur_idx <= dl_q.pred;
          state   <= S_AUG_B;
        end
        S_AUG_B: begin
          total <= total - aug_w;
          aug_v <= em_q.to_node;
          state <= S_AUG_R;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/mcbm_checker.sv
// Port-level checks on the matching block's result channel and edge ready, bound to the top level.
// Depends on mcbm_pkg and min_cost_bipartite_matching_top.
module mcbm_checker import mcbm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [COST_W-1:0] total_cost
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(total_cost))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NO_MATCH || status == ST_OVERFLOW))
    else $error("bad status code");

  a_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> total_cost == '0)
    else $error("cost nonzero on failure");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("edge taken while result pending");

endmodule

bind min_cost_bipartite_matching_top mcbm_checker u_mcbm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (edge_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .status     (result_out.status),
  .total_cost (result_out.total_cost)
);
